// ===== hw/rtl/hbp_pkg.sv =====
package hbp_pkg;

  // Default table size and longest code accepted on a load
  localparam int SYMBOL_COUNT = 256;
  localparam int MAX_CODE_LEN = 32;
  localparam int CODE_FIELD_BITS = 32;
  localparam int LEN_CAP = (MAX_CODE_LEN < CODE_FIELD_BITS) ? MAX_CODE_LEN : CODE_FIELD_BITS;

  // Bit buffer: seven pending bits plus a full code, top aligned
  localparam int BUF_BITS = 40;
  localparam int TOTAL_W = 6;

  // Depth of the command queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Opcodes of an input beat
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ENCODE = 2'd1;
  localparam logic [1:0] OP_FLUSH  = 2'd2;

  // Command kinds passed from front to back
  localparam logic [1:0] CMD_ENCODE = 2'd0;
  localparam logic [1:0] CMD_FLUSH  = 2'd1;
  localparam logic [1:0] CMD_ERROR  = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  symbol;
    logic [5:0]  code_len;
    logic [31:0] code_bits;
  } hbp_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       error_flag;
    logic       last_of_run;
  } hbp_out_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  len;
    logic [31:0] code;
  } hbp_cmd_t;

endpackage

// ===== hw/rtl/hbp_front.sv =====
module hbp_front #(
  parameter int SYMBOL_COUNT = hbp_pkg::SYMBOL_COUNT,
  parameter int QDEPTH = hbp_pkg::QUEUE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  hbp_pkg::hbp_in_t             item,
  input  logic [$clog2(QDEPTH+1)-1:0]  q_count,
  output logic                         busy,
  output logic                         push,
  output hbp_pkg::hbp_cmd_t            push_cmd
);

  localparam int IW = $clog2(SYMBOL_COUNT);
  localparam int CW = $clog2(QDEPTH+1);

  logic [37:0]             code_mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] entry_valid;
  logic [37:0]             rd_data;
  logic                    s1_valid;
  logic                    s1_flush;
  logic                    s1_err;
  logic                    accept;
  logic                    in_range;
  logic [IW-1:0]           idx;
  logic [5:0]              len_sat;
  logic                    is_load;
  logic                    is_encode;
  logic                    is_flush;

  // Hold off while the queue plus the beat in flight could fill it
  assign busy = ((CW+1)'(q_count) + (CW+1)'(s1_valid)) >= (CW+1)'(QDEPTH);
  assign accept = start && !busy;

  assign in_range  = {1'b0, item.symbol} < 9'(SYMBOL_COUNT);
  assign idx       = item.symbol[IW-1:0];
  assign is_load   = item.opcode == hbp_pkg::OP_LOAD;
  assign is_encode = item.opcode == hbp_pkg::OP_ENCODE;
  assign is_flush  = item.opcode == hbp_pkg::OP_FLUSH;
  assign len_sat   = (item.code_len > 6'(hbp_pkg::LEN_CAP)) ? 6'(hbp_pkg::LEN_CAP)
                                                            : item.code_len;

  // Code table: written on load, read registered on every cycle
  always_ff @(posedge clk) begin
    if (accept && is_load && in_range) begin
      code_mem[idx] <= {len_sat, item.code_bits};
    end
    rd_data <= code_mem[idx];
  end

  // Valid marks and the lookup stage
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      s1_valid    <= 1'b0;
    end else begin
      if (accept && is_load && in_range) begin
        entry_valid[idx] <= 1'b1;
      end
      s1_valid <= accept && (is_encode || is_flush);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_flush <= is_flush;
      s1_err   <= !(in_range && entry_valid[idx]);
    end
  end

  // Classify into a queue command
  always_comb begin
    push          = s1_valid;
    push_cmd.len  = rd_data[37:32];
    push_cmd.code = rd_data[31:0];
    if (s1_flush) begin
      push_cmd.kind = hbp_pkg::CMD_FLUSH;
    end else if (s1_err) begin
      push_cmd.kind = hbp_pkg::CMD_ERROR;
    end else begin
      push_cmd.kind = hbp_pkg::CMD_ENCODE;
    end
  end

endmodule

// ===== hw/rtl/hbp_queue.sv =====
module hbp_queue #(
  parameter int DEPTH = hbp_pkg::QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  hbp_pkg::hbp_cmd_t           push_cmd,
  input  logic                        pop,
  output hbp_pkg::hbp_cmd_t           head,
  output logic                        empty,
  output logic [$clog2(DEPTH+1)-1:0]  count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  hbp_pkg::hbp_cmd_t slots [DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic              do_pop;

  assign empty  = count == '0;
  assign head   = slots[rd_ptr];
  assign do_pop = pop && !empty;

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/hbp_back.sv =====
module hbp_back (
  input  logic              clk,
  input  logic              rst,
  input  hbp_pkg::hbp_cmd_t head,
  input  logic              empty,
  output logic              pop,
  output logic              strobe,
  output hbp_pkg::hbp_out_t result
);

  localparam int BB = hbp_pkg::BUF_BITS;
  localparam int TW = hbp_pkg::TOTAL_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic          state;
  logic [BB-1:0] bitbuf;
  logic [TW-1:0] total;
  logic [BB-1:0] code_top;
  logic [BB-1:0] merged;
  logic [TW-1:0] merged_total;

  assign pop = (state == ST_IDLE) && !empty;

  // Top-align the code, then slot it in after the pending bits
  assign code_top     = {head.code, 8'b0} << (6'd32 - head.len);
  assign merged       = bitbuf | (code_top >> total);
  assign merged_total = total + head.len;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      strobe <= 1'b0;
      bitbuf <= '0;
      total  <= '0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            unique case (head.kind)
              hbp_pkg::CMD_ENCODE: begin
                if (merged_total >= TW'(8)) begin
                  strobe             <= 1'b1;
                  result.out_byte    <= merged[BB-1 -: 8];
                  result.error_flag  <= 1'b0;
                  result.last_of_run <= merged_total < TW'(16);
                  bitbuf             <= merged << 8;
                  total              <= merged_total - TW'(8);
                  if (merged_total >= TW'(16)) begin
                    state <= ST_EMIT;
                  end
                end else begin
                  bitbuf <= merged;
                  total  <= merged_total;
                end
              end
              hbp_pkg::CMD_FLUSH: begin
                if (total != '0) begin
                  strobe             <= 1'b1;
                  result.out_byte    <= bitbuf[BB-1 -: 8];
                  result.error_flag  <= 1'b0;
                  result.last_of_run <= 1'b1;
                  bitbuf             <= '0;
                  total              <= '0;
                end
              end
              hbp_pkg::CMD_ERROR: begin
                strobe             <= 1'b1;
                result.out_byte    <= 8'd0;
                result.error_flag  <= 1'b1;
                result.last_of_run <= 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
        ST_EMIT: begin
          // One full byte per cycle until fewer than eight remain
          strobe             <= 1'b1;
          result.out_byte    <= bitbuf[BB-1 -: 8];
          result.error_flag  <= 1'b0;
          result.last_of_run <= total < TW'(16);
          bitbuf             <= bitbuf << 8;
          total              <= total - TW'(8);
          if (total < TW'(16)) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/huffman_encode_bit_packer.sv =====
// Huffman encoder with an MSB-first byte packer. A beat is taken when start
// is high and busy is low. A load beat writes one table entry and produces
// nothing; an encode beat produces zero to four bytes, an error beat (symbol
// never loaded) one result, a flush beat zero or one byte. Results appear on
// result for exactly one cycle each, marked by strobe, and cannot be held
// off; the bytes of one beat come on consecutive cycles with last_of_run on
// the final one. The front takes one beat per cycle while its four-entry
// command queue has room; the packer drains one command and then emits one
// byte per cycle, so an encode holds the packer until its last byte is out.
// A result passes through the table read register, the queue and the packer
// output register. Valid marks clear synchronously while rst is high.
module huffman_encode_bit_packer #(
  parameter int SYMBOL_COUNT = hbp_pkg::SYMBOL_COUNT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  hbp_pkg::hbp_in_t  item,
  output logic              strobe,
  output hbp_pkg::hbp_out_t result
);

  localparam int QD = hbp_pkg::QUEUE_DEPTH;

  logic                      push;
  hbp_pkg::hbp_cmd_t         push_cmd;
  hbp_pkg::hbp_cmd_t         head;
  logic                      empty;
  logic                      pop;
  logic [$clog2(QD+1)-1:0]   q_count;

  hbp_front #(
    .SYMBOL_COUNT (SYMBOL_COUNT),
    .QDEPTH       (QD)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .item     (item),
    .q_count  (q_count),
    .busy     (busy),
    .push     (push),
    .push_cmd (push_cmd)
  );

  hbp_queue #(
    .DEPTH (QD)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .count    (q_count)
  );

  hbp_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .empty  (empty),
    .pop    (pop),
    .strobe (strobe),
    .result (result)
  );

endmodule

// ===== hw/rtl/hbp_checker.sv =====
module hbp_checker (
  input logic              clk,
  input logic              rst,
  input logic              busy,
  input logic              strobe,
  input hbp_pkg::hbp_out_t result
);

  // No result straight out of reset
  a_quiet_after_reset: assert property (@(posedge clk) $past(rst) |-> !strobe)
    else $error("result beat right after reset");

  // Nothing is queued straight out of reset, so the block takes a beat
  a_ready_after_reset: assert property (@(posedge clk) $past(rst) |-> !busy)
    else $error("busy right after reset");

  // An error result stands alone and carries a zero byte
  a_error_alone: assert property (@(posedge clk) disable iff (rst)
    strobe && result.error_flag |-> result.last_of_run && result.out_byte == 8'd0)
    else $error("malformed error result");

  // Bytes of one run come back to back
  a_run_contiguous: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last_of_run |=> strobe)
    else $error("gap inside a run");

  // A run of data bytes is never cut short by an error
  a_run_no_error: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last_of_run |=> !result.error_flag)
    else $error("error inside a run");

endmodule

bind huffman_encode_bit_packer hbp_checker u_chk (.*);

// ===== tb/hbp_byte_checker.sv =====
module hbp_byte_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  hbp_pkg::hbp_in_t   item,
  input  logic               strobe,
  input  hbp_pkg::hbp_out_t  result,
  output int                 fail_count,
  output int                 waiting,
  output int                 result_count,
  output int                 error_count
);

  localparam int BYTE_W = 8;

  // Shadow of the code table and of the bit accumulator
  logic [31:0] code_store [hbp_pkg::SYMBOL_COUNT];
  logic [5:0]  len_store [hbp_pkg::SYMBOL_COUNT];
  logic        loaded [hbp_pkg::SYMBOL_COUNT];
  logic [6:0]  held_bits;
  int          held_count;

  // Bytes still owed by the block, oldest first
  hbp_pkg::hbp_out_t expected_bytes [$];

  int fails;
  int seen;
  int seen_errors;

  task automatic report(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    fails++;
  endtask

  // Queue one owed result at the back
  task automatic owe(input hbp_pkg::hbp_out_t r);
    expected_bytes.insert(expected_bytes.size(), r);
  endtask

  // Work out the bytes that one accepted beat owes
  task automatic pack_beat(input hbp_pkg::hbp_in_t b);
    logic [63:0]       acc;
    logic [63:0]       chunk;
    logic [14:0]       padded;
    hbp_pkg::hbp_out_t r;
    int                len;
    int                total;
    case (b.opcode)
      hbp_pkg::OP_LOAD: begin
        code_store[b.symbol] = b.code_bits;
        len_store[b.symbol] = (b.code_len > hbp_pkg::LEN_CAP) ? 6'(hbp_pkg::LEN_CAP)
                                                              : b.code_len;
        loaded[b.symbol] = 1'b1;
      end
      hbp_pkg::OP_ENCODE: begin
        if (!loaded[b.symbol]) begin
          // unknown symbol: a single error beat, accumulator untouched
          r.out_byte = 8'h00;
          r.error_flag = 1'b1;
          r.last_of_run = 1'b1;
          owe(r);
        end else begin
          len = len_store[b.symbol];
          acc = ({57'd0, held_bits} << len) |
                ({32'd0, code_store[b.symbol]} & ((64'd1 << len) - 64'd1));
          total = held_count + len;
          while (total >= BYTE_W) begin
            chunk = acc >> (total - BYTE_W);
            r.out_byte = chunk[7:0];
            r.error_flag = 1'b0;
            r.last_of_run = (total < 2 * BYTE_W);
            owe(r);
            total -= BYTE_W;
          end
          held_bits = acc[6:0] & ((7'd1 << total) - 7'd1);
          held_count = total;
        end
      end
      hbp_pkg::OP_FLUSH: begin
        // pad the leftover bits with zeros at the low end
        if (held_count != 0) begin
          padded = {8'd0, held_bits} << (BYTE_W - held_count);
          r.out_byte = padded[7:0];
          r.error_flag = 1'b0;
          r.last_of_run = 1'b1;
          owe(r);
          held_bits = '0;
          held_count = 0;
        end
      end
      default: ;
    endcase
  endtask

  // Compare each result beat with the oldest owed byte, then predict
  always @(posedge clk) begin
    hbp_pkg::hbp_out_t want;
    if (rst) begin
      foreach (loaded[i]) loaded[i] = 1'b0;
      held_bits = '0;
      held_count = 0;
      expected_bytes.delete();
    end else begin
      if (strobe) begin
        seen++;
        if (result.error_flag) seen_errors++;
        if (expected_bytes.size() == 0) begin
          report($sformatf("unexpected beat %02h err %b last %b",
                           result.out_byte, result.error_flag, result.last_of_run));
        end else begin
          want = expected_bytes.pop_front();
          if (result.out_byte !== want.out_byte ||
              result.error_flag !== want.error_flag ||
              result.last_of_run !== want.last_of_run)
            report($sformatf("beat %0d got %02h/%b/%b want %02h/%b/%b", seen,
                             result.out_byte, result.error_flag, result.last_of_run,
                             want.out_byte, want.error_flag, want.last_of_run));
        end
      end
      if (start && !busy) pack_beat(item);
    end
    fail_count <= fails;
    waiting <= expected_bytes.size();
    result_count <= seen;
    error_count <= seen_errors;
  end

endmodule

// ===== tb/huffman_encode_bit_packer_test.sv =====
module huffman_encode_bit_packer_test;

  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_BEATS = 245;
  localparam int TABLE_PRELOAD = 24;
  localparam int DRAIN_CYCLES = 30;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  hbp_pkg::hbp_in_t  item;
  logic              strobe;
  hbp_pkg::hbp_out_t result;

  int fail_count;
  int waiting;
  int result_count;
  int error_count;
  int beats_sent;
  int quiet_cycles;

  huffman_encode_bit_packer dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .strobe (strobe),
    .result (result)
  );

  hbp_byte_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .strobe       (strobe),
    .result       (result),
    .fail_count   (fail_count),
    .waiting      (waiting),
    .result_count (result_count),
    .error_count  (error_count)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog: too long without any beat moving ends the run
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
        $display("huffman_encode_bit_packer_test: errors");
        $finish;
      end
    end
  end

  function automatic hbp_pkg::hbp_in_t make_beat(input logic [1:0] op,
                                                 input logic [7:0] sym,
                                                 input logic [5:0] len,
                                                 input logic [31:0] bits);
    hbp_pkg::hbp_in_t b;
    b.opcode = op;
    b.symbol = sym;
    b.code_len = len;
    b.code_bits = bits;
    return b;
  endfunction

  // Present one beat and hold it until the block takes it
  task automatic send(input hbp_pkg::hbp_in_t b);
    @(negedge clk);
    start <= 1'b1;
    item <= b;
    do @(posedge clk); while (busy);
    beats_sent++;
  endtask

  task automatic pause(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  initial begin
    logic [7:0] loaded_syms [$];
    logic [7:0] sym;
    logic [5:0] len;
    int         pick;
    int         burst_left;

    start = 1'b0;
    item = '0;
    rst = 1'b1;
    beats_sent = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: errors, empty flush, spare opcode, corner code lengths
    send(make_beat(hbp_pkg::OP_ENCODE, 8'h00, 6'd5, 32'h1));
    send(make_beat(hbp_pkg::OP_FLUSH, 8'hFF, 6'd63, 32'hFFFF_FFFF));
    send(make_beat(OP_SPARE, 8'hAA, 6'd8, 32'h55));
    send(make_beat(hbp_pkg::OP_LOAD, 8'h00, 6'd0, 32'hDEAD_BEEF));
    send(make_beat(hbp_pkg::OP_ENCODE, 8'h00, 6'd0, 32'h0));
    send(make_beat(hbp_pkg::OP_LOAD, 8'hFF, 6'd32, 32'hFFFF_FFFF));
    send(make_beat(hbp_pkg::OP_LOAD, 8'h01, 6'd63, 32'hA5A5_5A5A));
    send(make_beat(hbp_pkg::OP_LOAD, 8'h02, 6'd3, 32'hFFFF_FFF5));
    send(make_beat(hbp_pkg::OP_LOAD, 8'h03, 6'd1, 32'h0));
    send(make_beat(hbp_pkg::OP_LOAD, 8'h04, 6'd8, 32'h0000_0000));
    send(make_beat(hbp_pkg::OP_ENCODE, 8'h02, 6'd0, 32'h0));
    send(make_beat(hbp_pkg::OP_ENCODE, 8'hFF, 6'd0, 32'h0));
    send(make_beat(hbp_pkg::OP_ENCODE, 8'h01, 6'd0, 32'h0));
    send(make_beat(hbp_pkg::OP_ENCODE, 8'h03, 6'd0, 32'h0));
    send(make_beat(hbp_pkg::OP_ENCODE, 8'h80, 6'd0, 32'h0));
    send(make_beat(hbp_pkg::OP_FLUSH, 8'h00, 6'd0, 32'h0));
    send(make_beat(hbp_pkg::OP_ENCODE, 8'h04, 6'd0, 32'h0));
    send(make_beat(hbp_pkg::OP_ENCODE, 8'h02, 6'd0, 32'h0));
    send(make_beat(hbp_pkg::OP_FLUSH, 8'h00, 6'd0, 32'h0));
    send(make_beat(hbp_pkg::OP_LOAD, 8'h02, 6'd7, 32'h0000_007F));
    send(make_beat(hbp_pkg::OP_ENCODE, 8'h02, 6'd0, 32'h0));
    send(make_beat(hbp_pkg::OP_ENCODE, 8'h01, 6'd0, 32'h0));
    send(make_beat(hbp_pkg::OP_LOAD, 8'h05, 6'd33, 32'h8000_0001));
    send(make_beat(hbp_pkg::OP_ENCODE, 8'h05, 6'd0, 32'h0));
    send(make_beat(hbp_pkg::OP_FLUSH, 8'h00, 6'd0, 32'h0));
    loaded_syms = '{8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'hFF};

    // Random: fill part of the table, then a mix weighted towards encodes
    burst_left = 0;
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (burst_left == 0) begin
        if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 8));
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      pick = (n < TABLE_PRELOAD) ? 0 : int'($urandom_range(0, 99));
      sym = 8'($urandom_range(0, 255));
      if (pick < 22) begin
        case ($urandom_range(0, 19))
          0:       len = 6'd0;
          1:       len = 6'($urandom_range(33, 63));
          2, 3:    len = 6'($urandom_range(17, 32));
          default: len = 6'($urandom_range(1, 12));
        endcase
        send(make_beat(hbp_pkg::OP_LOAD, sym, len, $urandom));
        loaded_syms.insert(loaded_syms.size(), sym);
      end else if (pick < 80) begin
        if ($urandom_range(0, 9) != 0)
          sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
        send(make_beat(hbp_pkg::OP_ENCODE, sym, 6'($urandom_range(0, 63)), $urandom));
      end else if (pick < 95) begin
        send(make_beat(hbp_pkg::OP_FLUSH, sym, 6'($urandom_range(0, 63)), $urandom));
      end else begin
        send(make_beat(OP_SPARE, sym, 6'($urandom_range(0, 63)), $urandom));
      end
    end
    @(negedge clk);
    start <= 1'b0;

    // Let the owed bytes come out, then allow for stragglers
    while (waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d command beats; %0d result beats checked, %0d of them errors",
             beats_sent, result_count, error_count);
    if (fail_count == 0 && waiting == 0) begin
      $display("huffman_encode_bit_packer_test: clean");
    end else begin
      $display("%0d mismatches, %0d bytes still owed", fail_count, waiting);
      $display("huffman_encode_bit_packer_test: errors");
    end
    $finish;
  end

endmodule
